// File: src/feature_normalization_engine_top_defines.svh
// Assertion macros shared by the feature normalisation engine checker.
`ifndef FEATURE_NORMALIZATION_ENGINE_TOP_DEFINES_SVH
`define FEATURE_NORMALIZATION_ENGINE_TOP_DEFINES_SVH

// Assertion on an explicit clock and active-low reset.
`define FNE_ASSERT_CLK(lbl, clk_sig, rst_sig, prop, msg) \
    lbl: assert property (@(posedge clk_sig) disable iff (!rst_sig) prop) else $error(msg);

// Assertion on the block clock and reset.
`define FNE_ASSERT(lbl, prop, msg) `FNE_ASSERT_CLK(lbl, clk, rst_n, prop, msg)

`endif

// File: src/fne_pkg.sv
// Codes, types and saturation helpers of the feature normalisation engine.
package fne_pkg;

    typedef logic signed [31:0] q_t;

    localparam logic [2:0] CMD_CLEAR    = 3'd0;
    localparam logic [2:0] CMD_LOAD     = 3'd1;
    localparam logic [2:0] CMD_FINALIZE = 3'd2;
    localparam logic [2:0] CMD_SCALE    = 3'd3;
    localparam logic [2:0] CMD_DESCALE  = 3'd4;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_FULL = 2'd1;
    localparam logic [1:0] ST_FEW  = 2'd2;
    localparam logic [1:0] ST_ZERO = 2'd3;

    localparam logic [1:0] MODE_NONE    = 2'd0;
    localparam logic [1:0] MODE_MINMAX  = 2'd1;
    localparam logic [1:0] MODE_STDDEV  = 2'd2;
    localparam logic [1:0] MODE_UNIFORM = 2'd3;

    localparam logic [2:0] REG_MODE       = 3'd0;
    localparam logic [2:0] REG_TARGET_MIN = 3'd1;
    localparam logic [2:0] REG_TARGET_MAX = 3'd2;
    localparam logic [2:0] REG_DEV_GAIN   = 3'd3;
    localparam logic [2:0] REG_NORM_GAIN  = 3'd4;

    localparam logic [40:0] CLAMP_MAG = 41'h100_0000_0000;

    localparam q_t Q_MAX = 32'sh7fff_ffff;
    localparam q_t Q_MIN = 32'sh8000_0000;

    function automatic logic [31:0] abs33(input logic signed [32:0] v);
        logic signed [32:0] n;
        n = -v;
        return v[32] ? n[31:0] : v[31:0];
    endfunction

    function automatic q_t sat_add(input logic [40:0] mag, input logic neg, input q_t addend);
        logic signed [42:0] v;
        v = neg ? -$signed({2'b00, mag}) : $signed({2'b00, mag});
        v = v + 43'(addend);
        if (v > 43'(Q_MAX))
        begin
            return Q_MAX;
        end
        if (v < 43'(Q_MIN))
        begin
            return Q_MIN;
        end
        return v[31:0];
    endfunction

endpackage

// File: src/fne_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module fne_ram
#(
    parameter int WIDTH = 32,
    parameter int DEPTH = 512
)
(
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: src/feature_normalization_engine_top.sv
// Top level of the feature normalisation engine: sequencer, shared units and statistics.
//
// The engine takes one command per transfer and returns exactly one result transfer for
// it. A min-max scale runs through the single 32x32 multiplier in two passes. A min-max
// descale and a z-score or uniform-norm scale go through the radix-2 divider, one
// quotient bit per cycle over 64 + clog2(SAMPLES_PER_SIDE + 1) bits. Finalise reads the
// sample buffer through its one read port; for standard deviation it also needs the
// divider twice and a 32-step square root. The sample memory needs no clearing after
// reset.
module feature_normalization_engine_top
    import fne_pkg::*;
#(
    parameter int SAMPLES_PER_SIDE = 256,
    parameter int FRACTION_BITS    = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // sample
    input  logic [3:0]  s_tuser,   // command [2:0], side [3]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // result_value
    output logic [1:0]  m_tuser,   // status
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    localparam int CNT_W   = $clog2(SAMPLES_PER_SIDE + 1);
    localparam int IDX_W   = $clog2(SAMPLES_PER_SIDE);
    localparam int SUM_W   = 32 + CNT_W;
    localparam int SQ_W    = 64 + CNT_W;
    localparam int DVD_W   = SQ_W;
    localparam int DVS_W   = 63 - FRACTION_BITS;
    localparam int DCNT_W  = $clog2(DVD_W);
    localparam int RAM_D   = 2 << IDX_W;
    localparam int ACC_W   = 96;
    localparam logic [31:0] ONE_Q = 32'(64'd1 << FRACTION_BITS);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(SAMPLES_PER_SIDE);

    localparam logic [4:0] S_IDLE   = 5'd0;
    localparam logic [4:0] S_DECODE = 5'd1;
    localparam logic [4:0] S_DONE   = 5'd2;
    localparam logic [4:0] S_W_ADDR = 5'd3;
    localparam logic [4:0] S_W_DATA = 5'd4;
    localparam logic [4:0] S_MM_END = 5'd5;
    localparam logic [4:0] S_DIV    = 5'd6;
    localparam logic [4:0] S_DIVEND = 5'd7;
    localparam logic [4:0] S_V_ADDR = 5'd8;
    localparam logic [4:0] S_V_DATA = 5'd9;
    localparam logic [4:0] S_V_MW   = 5'd10;
    localparam logic [4:0] S_V_MP   = 5'd11;
    localparam logic [4:0] S_V_END  = 5'd12;
    localparam logic [4:0] S_SQRT   = 5'd13;
    localparam logic [4:0] S_SQEND  = 5'd14;
    localparam logic [4:0] S_D_W    = 5'd15;
    localparam logic [4:0] S_D_P    = 5'd16;
    localparam logic [4:0] S_D_CHK  = 5'd17;
    localparam logic [4:0] S_MQ_W0  = 5'd18;
    localparam logic [4:0] S_MQ_P0  = 5'd19;
    localparam logic [4:0] S_MQ_W1  = 5'd20;
    localparam logic [4:0] S_MQ_P1  = 5'd21;
    localparam logic [4:0] S_MQ_END = 5'd22;

    localparam logic [1:0] JOB_MEAN = 2'd0;
    localparam logic [1:0] JOB_FAC  = 2'd1;
    localparam logic [1:0] JOB_XF   = 2'd2;
    localparam logic [1:0] JOB_VAR  = 2'd3;

    localparam logic [4:0] SQ_LAST = 5'd31;

    logic [4:0]  state_reg;
    logic [2:0]  cmd_reg;
    logic        side_reg;
    q_t          x_reg;

    logic [1:0]  mode_reg;
    q_t          tmin_reg;
    q_t          tmax_reg;
    logic [30:0] dgain_reg;
    logic [30:0] ngain_reg;

    logic [CNT_W-1:0]        count_reg   [2];
    logic signed [SUM_W-1:0] sum_reg     [2];
    q_t                      min_reg     [2];
    q_t                      max_reg     [2];
    q_t                      mean_reg    [2];
    logic [31:0]             divisor_reg [2];
    q_t                      factor_reg  [2];

    logic [IDX_W-1:0]  idx_reg;
    q_t                lo_reg;
    q_t                hi_reg;
    q_t                wmean_reg;
    logic [SQ_W-1:0]   ssq_reg;
    logic [31:0]       maxdev_reg;

    logic [31:0]       mul_a_reg;
    logic [31:0]       mul_b_reg;
    logic [31:0]       bhi_reg;
    logic [63:0]       prod_reg;
    logic [ACC_W-1:0]  acc_reg;
    logic [DVS_W-1:0]  d_reg;

    logic [DVD_W-1:0]  dvd_reg;
    logic [DVS_W-1:0]  dvs_reg;
    logic [DVS_W-1:0]  rem_reg;
    logic [DVD_W-1:0]  quo_reg;
    logic [DCNT_W-1:0] dcnt_reg;
    logic [1:0]        job_reg;
    logic              neg_reg;
    q_t                addend_reg;

    logic [63:0]       sq_v_reg;
    logic [63:0]       sq_res_reg;
    logic [63:0]       sq_bit_reg;
    logic [4:0]        sq_cnt_reg;

    q_t                res_reg;
    logic [1:0]        st_reg;
    logic              m_tvalid_reg;
    logic [31:0]       m_data_reg;
    logic [1:0]        m_st_reg;

    logic [CNT_W-1:0]        cur_count;
    logic signed [SUM_W-1:0] cur_sum;
    logic [SUM_W-1:0]        abs_sum;
    q_t                      cur_min;
    q_t                      cur_mean;
    logic [31:0]             cur_divisor;
    q_t                      cur_factor;
    logic [30:0]             gain_sel;
    logic                    walk_last;
    logic [CNT_W-1:0]        count_m1;

    logic                    ram_we;
    logic [IDX_W:0]          ram_waddr;
    logic [IDX_W:0]          ram_raddr;
    logic [31:0]             ram_rdata;
    q_t                      rd_val;

    logic signed [32:0] xmin_diff;
    logic signed [32:0] xtmin_diff;
    logic signed [32:0] xmean_diff;
    logic signed [32:0] tdiff;
    logic signed [32:0] span;
    logic signed [32:0] dev;
    logic [31:0]        dev_mag;
    logic [63:0]        d_wide;

    logic [DVS_W:0]     rem_sh;
    logic [DVS_W:0]     rem_sub;
    logic               rem_ge;
    logic [40:0]        div_mag;
    logic [32:0]        mean_m;
    logic [32:0]        mean_s;

    logic [ACC_W-1:0]   mq_q;
    logic               mq_rem;
    logic [ACC_W-1:0]   mq_qi;
    logic [40:0]        mq_mag;
    logic [63:0]        sq_sum;

    fne_ram
    #(
        .WIDTH (32),
        .DEPTH (RAM_D)
    )
    u_store
    (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (x_reg),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        cur_count   = count_reg[side_reg];
        cur_sum     = sum_reg[side_reg];
        abs_sum     = cur_sum[SUM_W-1] ? SUM_W'(-cur_sum) : SUM_W'(cur_sum);
        cur_min     = min_reg[side_reg];
        cur_mean    = mean_reg[side_reg];
        cur_divisor = divisor_reg[side_reg];
        cur_factor  = factor_reg[side_reg];
        gain_sel    = (mode_reg == MODE_STDDEV) ? dgain_reg : ngain_reg;
        count_m1    = cur_count - CNT_W'(1);
        walk_last   = (CNT_W'(idx_reg) == count_m1);

        ram_we    = (state_reg == S_DECODE) && (cmd_reg == CMD_LOAD) && (cur_count < FULL_CNT);
        ram_waddr = {side_reg, cur_count[IDX_W-1:0]};
        ram_raddr = {side_reg, idx_reg};
        rd_val    = ram_rdata;

        xmin_diff  = {x_reg[31], x_reg} - {cur_min[31], cur_min};
        xtmin_diff = {x_reg[31], x_reg} - {tmin_reg[31], tmin_reg};
        xmean_diff = {x_reg[31], x_reg} - {cur_mean[31], cur_mean};
        tdiff      = {tmax_reg[31], tmax_reg} - {tmin_reg[31], tmin_reg};
        span       = {hi_reg[31], hi_reg} - {lo_reg[31], lo_reg};
        dev        = {rd_val[31], rd_val} - {wmean_reg[31], wmean_reg};
        dev_mag    = abs33(dev);
        d_wide     = 64'(d_reg);

        rem_sh  = {rem_reg, dvd_reg[DVD_W-1]};
        rem_ge  = (rem_sh >= {1'b0, dvs_reg});
        rem_sub = rem_sh - {1'b0, dvs_reg};
        div_mag = (quo_reg > DVD_W'(CLAMP_MAG)) ? CLAMP_MAG : quo_reg[40:0];
        mean_m  = {1'b0, quo_reg[31:0]};
        mean_s  = neg_reg ? -mean_m : mean_m;

        mq_q   = acc_reg >> FRACTION_BITS;
        mq_rem = |(acc_reg & ((ACC_W'(1) << FRACTION_BITS) - ACC_W'(1)));
        mq_qi  = mq_q + ACC_W'(neg_reg && mq_rem);
        mq_mag = (mq_qi > ACC_W'(CLAMP_MAG)) ? CLAMP_MAG : mq_qi[40:0];

        sq_sum = sq_res_reg + sq_bit_reg;
    end

    assign s_tready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_data_reg;
    assign m_tuser   = m_st_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            cmd_reg      <= CMD_CLEAR;
            side_reg     <= 1'b0;
            x_reg        <= '0;
            mode_reg     <= MODE_NONE;
            tmin_reg     <= -$signed(ONE_Q);
            tmax_reg     <= ONE_Q;
            dgain_reg    <= 31'(ONE_Q);
            ngain_reg    <= 31'(ONE_Q);
            for (int i = 0; i < 2; i++)
            begin
                count_reg[i]   <= '0;
                sum_reg[i]     <= '0;
                min_reg[i]     <= Q_MAX;
                max_reg[i]     <= Q_MIN;
                mean_reg[i]    <= '0;
                divisor_reg[i] <= ONE_Q;
                factor_reg[i]  <= ONE_Q;
            end
            idx_reg      <= '0;
            lo_reg       <= '0;
            hi_reg       <= '0;
            wmean_reg    <= '0;
            ssq_reg      <= '0;
            maxdev_reg   <= '0;
            mul_a_reg    <= '0;
            mul_b_reg    <= '0;
            bhi_reg      <= '0;
            prod_reg     <= '0;
            acc_reg      <= '0;
            d_reg        <= '0;
            dvd_reg      <= '0;
            dvs_reg      <= '0;
            rem_reg      <= '0;
            quo_reg      <= '0;
            dcnt_reg     <= '0;
            job_reg      <= JOB_MEAN;
            neg_reg      <= 1'b0;
            addend_reg   <= '0;
            sq_v_reg     <= '0;
            sq_res_reg   <= '0;
            sq_bit_reg   <= '0;
            sq_cnt_reg   <= '0;
            res_reg      <= '0;
            st_reg       <= ST_OK;
            m_tvalid_reg <= 1'b0;
            m_data_reg   <= '0;
            m_st_reg     <= ST_OK;
        end
        else
        begin
            prod_reg <= 64'(mul_a_reg) * 64'(mul_b_reg);

            if (cfg_valid)
            begin
                case (cfg_index)
                    REG_MODE:       mode_reg  <= cfg_data[1:0];
                    REG_TARGET_MIN: tmin_reg  <= cfg_data;
                    REG_TARGET_MAX: tmax_reg  <= cfg_data;
                    REG_DEV_GAIN:   dgain_reg <= cfg_data[30:0];
                    REG_NORM_GAIN:  ngain_reg <= cfg_data[30:0];
                    default:        ;
                endcase
            end

            if (m_tvalid_reg && m_tready && (state_reg != S_DONE))
            begin
                m_tvalid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        cmd_reg   <= s_tuser[2:0];
                        side_reg  <= s_tuser[3];
                        x_reg     <= s_tdata;
                        state_reg <= S_DECODE;
                    end
                end

                S_DECODE:
                begin
                    rem_reg   <= '0;
                    quo_reg   <= '0;
                    dcnt_reg  <= '0;
                    case (cmd_reg)
                        CMD_CLEAR:
                        begin
                            count_reg[side_reg] <= '0;
                            sum_reg[side_reg]   <= '0;
                            state_reg           <= S_DONE;
                        end
                        CMD_LOAD:
                        begin
                            state_reg <= S_DONE;
                            if (cur_count >= FULL_CNT)
                            begin
                                st_reg <= ST_FULL;
                            end
                            else
                            begin
                                count_reg[side_reg] <= cur_count + CNT_W'(1);
                                sum_reg[side_reg]   <= cur_sum + SUM_W'(x_reg);
                            end
                        end
                        CMD_FINALIZE:
                        begin
                            case (mode_reg)
                                MODE_MINMAX:
                                begin
                                    if (cur_count == '0)
                                    begin
                                        st_reg    <= ST_FEW;
                                        state_reg <= S_DONE;
                                    end
                                    else
                                    begin
                                        idx_reg   <= '0;
                                        lo_reg    <= Q_MAX;
                                        hi_reg    <= Q_MIN;
                                        state_reg <= S_W_ADDR;
                                    end
                                end
                                MODE_STDDEV, MODE_UNIFORM:
                                begin
                                    if (cur_count < ((mode_reg == MODE_STDDEV) ? CNT_W'(2)
                                                                               : CNT_W'(1)))
                                    begin
                                        st_reg    <= ST_FEW;
                                        state_reg <= S_DONE;
                                    end
                                    else
                                    begin
                                        dvd_reg   <= DVD_W'(abs_sum);
                                        dvs_reg   <= DVS_W'(cur_count);
                                        neg_reg   <= cur_sum[SUM_W-1];
                                        job_reg   <= JOB_MEAN;
                                        state_reg <= S_DIV;
                                    end
                                end
                                default:
                                begin
                                    state_reg <= S_DONE;
                                end
                            endcase
                        end
                        CMD_SCALE, CMD_DESCALE:
                        begin
                            case (mode_reg)
                                MODE_NONE:
                                begin
                                    res_reg   <= x_reg;
                                    state_reg <= S_DONE;
                                end
                                MODE_MINMAX:
                                begin
                                    if (cmd_reg == CMD_SCALE)
                                    begin
                                        mul_a_reg  <= abs33(xmin_diff);
                                        mul_b_reg  <= abs33({cur_factor[31], cur_factor});
                                        bhi_reg    <= '0;
                                        neg_reg    <= xmin_diff[32] ^ cur_factor[31];
                                        addend_reg <= tmin_reg;
                                        state_reg  <= S_MQ_W0;
                                    end
                                    else if (cur_factor == '0)
                                    begin
                                        st_reg    <= ST_ZERO;
                                        state_reg <= S_DONE;
                                    end
                                    else
                                    begin
                                        dvd_reg    <= DVD_W'({abs33(xtmin_diff),
                                                              FRACTION_BITS'(0)});
                                        dvs_reg    <= DVS_W'(abs33({cur_factor[31], cur_factor}));
                                        neg_reg    <= xtmin_diff[32] ^ cur_factor[31];
                                        addend_reg <= cur_min;
                                        job_reg    <= JOB_XF;
                                        state_reg  <= S_DIV;
                                    end
                                end
                                default:
                                begin
                                    mul_a_reg <= cur_divisor;
                                    mul_b_reg <= {1'b0, gain_sel};
                                    state_reg <= S_D_W;
                                end
                            endcase
                        end
                        default:
                        begin
                            state_reg <= S_DONE;
                        end
                    endcase
                end

                S_W_ADDR:
                begin
                    state_reg <= S_W_DATA;
                end

                S_W_DATA:
                begin
                    if (rd_val < lo_reg)
                    begin
                        lo_reg <= rd_val;
                    end
                    if (rd_val > hi_reg)
                    begin
                        hi_reg <= rd_val;
                    end
                    idx_reg   <= idx_reg + IDX_W'(1);
                    state_reg <= walk_last ? S_MM_END : S_W_ADDR;
                end

                S_MM_END:
                begin
                    if (span == '0)
                    begin
                        st_reg    <= ST_ZERO;
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        dvd_reg   <= DVD_W'({abs33(tdiff), FRACTION_BITS'(0)});
                        dvs_reg   <= DVS_W'(span[31:0]);
                        neg_reg   <= tdiff[32];
                        job_reg   <= JOB_FAC;
                        state_reg <= S_DIV;
                    end
                end

                S_DIV:
                begin
                    rem_reg  <= rem_ge ? rem_sub[DVS_W-1:0] : rem_sh[DVS_W-1:0];
                    quo_reg  <= {quo_reg[DVD_W-2:0], rem_ge};
                    dvd_reg  <= {dvd_reg[DVD_W-2:0], 1'b0};
                    dcnt_reg <= dcnt_reg + DCNT_W'(1);
                    if (dcnt_reg == DCNT_W'(DVD_W - 1))
                    begin
                        state_reg <= S_DIVEND;
                    end
                end

                S_DIVEND:
                begin
                    case (job_reg)
                        JOB_MEAN:
                        begin
                            wmean_reg  <= mean_s[31:0];
                            ssq_reg    <= '0;
                            maxdev_reg <= '0;
                            idx_reg    <= '0;
                            state_reg  <= S_V_ADDR;
                        end
                        JOB_FAC:
                        begin
                            min_reg[side_reg]    <= lo_reg;
                            max_reg[side_reg]    <= hi_reg;
                            factor_reg[side_reg] <= sat_add(div_mag, neg_reg, '0);
                            state_reg            <= S_DONE;
                        end
                        JOB_XF:
                        begin
                            res_reg   <= sat_add(div_mag, neg_reg, addend_reg);
                            state_reg <= S_DONE;
                        end
                        default:
                        begin
                            sq_v_reg   <= quo_reg[63:0];
                            sq_res_reg <= '0;
                            sq_bit_reg <= 64'd1 << 62;
                            sq_cnt_reg <= '0;
                            state_reg  <= S_SQRT;
                        end
                    endcase
                end

                S_V_ADDR:
                begin
                    state_reg <= S_V_DATA;
                end

                S_V_DATA:
                begin
                    if (mode_reg == MODE_UNIFORM)
                    begin
                        if (dev_mag > maxdev_reg)
                        begin
                            maxdev_reg <= dev_mag;
                        end
                        idx_reg   <= idx_reg + IDX_W'(1);
                        state_reg <= walk_last ? S_V_END : S_V_ADDR;
                    end
                    else
                    begin
                        mul_a_reg <= dev_mag;
                        mul_b_reg <= dev_mag;
                        state_reg <= S_V_MW;
                    end
                end

                S_V_MW:
                begin
                    state_reg <= S_V_MP;
                end

                S_V_MP:
                begin
                    ssq_reg   <= ssq_reg + SQ_W'(prod_reg);
                    idx_reg   <= idx_reg + IDX_W'(1);
                    state_reg <= walk_last ? S_V_END : S_V_ADDR;
                end

                S_V_END:
                begin
                    if (mode_reg == MODE_UNIFORM)
                    begin
                        state_reg <= S_DONE;
                        if (maxdev_reg == '0)
                        begin
                            st_reg <= ST_ZERO;
                        end
                        else
                        begin
                            mean_reg[side_reg]    <= wmean_reg;
                            divisor_reg[side_reg] <= maxdev_reg;
                        end
                    end
                    else if (ssq_reg[SQ_W-1:64] >= count_m1)
                    begin
                        mean_reg[side_reg]    <= wmean_reg;
                        divisor_reg[side_reg] <= 32'hffff_ffff;
                        state_reg             <= S_DONE;
                    end
                    else
                    begin
                        dvd_reg   <= ssq_reg;
                        dvs_reg   <= DVS_W'(count_m1);
                        neg_reg   <= 1'b0;
                        rem_reg   <= '0;
                        quo_reg   <= '0;
                        dcnt_reg  <= '0;
                        job_reg   <= JOB_VAR;
                        state_reg <= S_DIV;
                    end
                end

                S_SQRT:
                begin
                    if (sq_v_reg >= sq_sum)
                    begin
                        sq_v_reg   <= sq_v_reg - sq_sum;
                        sq_res_reg <= (sq_res_reg >> 1) + sq_bit_reg;
                    end
                    else
                    begin
                        sq_res_reg <= sq_res_reg >> 1;
                    end
                    sq_bit_reg <= sq_bit_reg >> 2;
                    sq_cnt_reg <= sq_cnt_reg + 5'd1;
                    if (sq_cnt_reg == SQ_LAST)
                    begin
                        state_reg <= S_SQEND;
                    end
                end

                S_SQEND:
                begin
                    if (sq_res_reg[31:0] == '0)
                    begin
                        st_reg <= ST_ZERO;
                    end
                    else
                    begin
                        mean_reg[side_reg]    <= wmean_reg;
                        divisor_reg[side_reg] <= sq_res_reg[31:0];
                    end
                    state_reg <= S_DONE;
                end

                S_D_W:
                begin
                    state_reg <= S_D_P;
                end

                S_D_P:
                begin
                    d_reg     <= DVS_W'(prod_reg >> FRACTION_BITS);
                    state_reg <= S_D_CHK;
                end

                S_D_CHK:
                begin
                    if (d_reg == '0)
                    begin
                        st_reg    <= ST_ZERO;
                        state_reg <= S_DONE;
                    end
                    else if (cmd_reg == CMD_SCALE)
                    begin
                        dvd_reg    <= DVD_W'({abs33(xmean_diff), FRACTION_BITS'(0)});
                        dvs_reg    <= d_reg;
                        neg_reg    <= xmean_diff[32];
                        addend_reg <= '0;
                        job_reg    <= JOB_XF;
                        state_reg  <= S_DIV;
                    end
                    else
                    begin
                        mul_a_reg  <= abs33({x_reg[31], x_reg});
                        mul_b_reg  <= d_wide[31:0];
                        bhi_reg    <= d_wide[63:32];
                        neg_reg    <= x_reg[31];
                        addend_reg <= cur_mean;
                        state_reg  <= S_MQ_W0;
                    end
                end

                S_MQ_W0:
                begin
                    state_reg <= S_MQ_P0;
                end

                S_MQ_P0:
                begin
                    acc_reg   <= ACC_W'(prod_reg);
                    mul_b_reg <= bhi_reg;
                    state_reg <= S_MQ_W1;
                end

                S_MQ_W1:
                begin
                    state_reg <= S_MQ_P1;
                end

                S_MQ_P1:
                begin
                    acc_reg   <= acc_reg + {prod_reg, 32'd0};
                    state_reg <= S_MQ_END;
                end

                S_MQ_END:
                begin
                    res_reg   <= sat_add(mq_mag, neg_reg, addend_reg);
                    state_reg <= S_DONE;
                end

                S_DONE:
                begin
                    if (!m_tvalid_reg || m_tready)
                    begin
                        m_tvalid_reg <= 1'b1;
                        m_data_reg   <= res_reg;
                        m_st_reg     <= st_reg;
                        res_reg      <= '0;
                        st_reg       <= ST_OK;
                        state_reg    <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// File: src/fne_checker.sv
// Port-level assertion checker of the feature normalisation engine and its bind.
`include "feature_normalization_engine_top_defines.svh"

module fne_checker
    import fne_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic [1:0]  m_tuser
);

    // An accepted command moves on to decode, so no transfer follows directly.
    `FNE_ASSERT(a_busy_after_accept, (s_tvalid && s_tready) |=> !s_tready, "ready right after accept")

    // Any failure status carries a zero value.
    `FNE_ASSERT(a_zero_on_error, (m_tvalid && (m_tuser != ST_OK)) |-> (m_tdata == 32'd0), "nonzero value with error status")

    `FNE_ASSERT(a_out_hold, (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)), "result changed while stalled")

endmodule

bind feature_normalization_engine_top fne_checker u_fne_checker (.*);

// File: dv/tb.sv
// Self-checking testbench for the feature normalisation engine top level.
module tb;
    import fne_pkg::*;

    typedef struct packed {
        logic [31:0] value;
        logic [1:0]  status;
    } norm_result_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic [3:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [31:0] cfg_data;

    norm_result_t pending_results[$];
    int           mismatches;
    int           idle_pct;
    int           stall_pct;

    logic [1:0]         sh_mode;
    logic signed [31:0] sh_tmin;
    logic signed [31:0] sh_tmax;
    logic [30:0]        sh_dgain;
    logic [30:0]        sh_ngain;

    logic signed [31:0] buf_mem [2][256];
    int                 buf_count [2];
    longint             buf_sum [2];
    logic signed [31:0] stat_min [2];
    logic signed [31:0] stat_max [2];
    logic signed [31:0] stat_mean [2];
    logic [31:0]        stat_div [2];
    logic signed [31:0] stat_factor [2];

    feature_normalization_engine_top uut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    initial
    begin
        #100_000_000;
        $display("feature_normalization_engine_top verification failed");
        $finish;
    end

    function automatic longint sat32(input longint v);
        if (v > longint'(Q_MAX))
        begin
            return longint'(Q_MAX);
        end
        if (v < longint'(Q_MIN))
        begin
            return longint'(Q_MIN);
        end
        return v;
    endfunction

    function automatic longint floor_mul_q(input longint a, input longint b);
        logic signed [127:0] pa;
        logic signed [127:0] pb;
        logic signed [127:0] p;
        pa = a;
        pb = b;
        p = (pa * pb) >>> 16;
        if (p > 128'sd1099511627776)
        begin
            p = 128'sd1099511627776;
        end
        if (p < -128'sd1099511627776)
        begin
            p = -128'sd1099511627776;
        end
        return p[63:0];
    endfunction

    function automatic logic [31:0] int_sqrt(input logic [63:0] v);
        logic [63:0] r;
        logic [63:0] b;
        r = 0;
        b = 64'h4000_0000_0000_0000;
        while (b > v)
        begin
            b = b >> 2;
        end
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end
            else
            begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r[31:0];
    endfunction

    function automatic logic [1:0] finalize_stats(input int s);
        int           n;
        longint       lo;
        longint       hi;
        longint       span;
        longint       mean;
        longint       dv;
        logic [63:0]  mag;
        logic [63:0]  dmax;
        logic [127:0] ssq;
        logic [127:0] var_q;
        logic [31:0]  root;
        n = buf_count[s];
        if (sh_mode == MODE_MINMAX)
        begin
            if (n == 0)
            begin
                return ST_FEW;
            end
            lo = longint'(Q_MAX);
            hi = longint'(Q_MIN);
            for (int i = 0; i < n; i++)
            begin
                if (buf_mem[s][i] < lo) lo = buf_mem[s][i];
                if (buf_mem[s][i] > hi) hi = buf_mem[s][i];
            end
            span = hi - lo;
            if (span == 0)
            begin
                return ST_ZERO;
            end
            stat_min[s] = lo[31:0];
            stat_max[s] = hi[31:0];
            stat_factor[s] = sat32((longint'(sh_tmax) - longint'(sh_tmin)) * 65536 / span);
            return ST_OK;
        end
        if (sh_mode == MODE_NONE)
        begin
            return ST_OK;
        end
        if (n < ((sh_mode == MODE_STDDEV) ? 2 : 1))
        begin
            return ST_FEW;
        end
        mean = buf_sum[s] / n;
        ssq = 0;
        dmax = 0;
        for (int i = 0; i < n; i++)
        begin
            dv = longint'(buf_mem[s][i]) - mean;
            mag = (dv < 0) ? -dv : dv;
            ssq = ssq + 128'(mag) * 128'(mag);
            if (mag > dmax) dmax = mag;
        end
        if (sh_mode == MODE_STDDEV)
        begin
            var_q = ssq / (n - 1);
            root = (var_q[127:64] != 0) ? int_sqrt(64'hffff_ffff_ffff_ffff)
                                        : int_sqrt(var_q[63:0]);
            dmax = root;
        end
        if (dmax == 0)
        begin
            return ST_ZERO;
        end
        stat_mean[s] = mean[31:0];
        stat_div[s] = (dmax > 64'hffff_ffff) ? 32'hffff_ffff : dmax[31:0];
        return ST_OK;
    endfunction

    function automatic norm_result_t predict_result(input logic [2:0] cmd, input int s,
                                                    input logic signed [31:0] x);
        norm_result_t r;
        longint       d;
        logic [63:0]  prod;
        r.value = 0;
        r.status = ST_OK;
        case (cmd)
            CMD_CLEAR:
            begin
                buf_count[s] = 0;
                buf_sum[s] = 0;
            end
            CMD_LOAD:
            begin
                if (buf_count[s] >= 256)
                begin
                    r.status = ST_FULL;
                end
                else
                begin
                    buf_mem[s][buf_count[s]] = x;
                    buf_count[s]++;
                    buf_sum[s] += x;
                end
            end
            CMD_FINALIZE:
            begin
                r.status = finalize_stats(s);
            end
            CMD_SCALE, CMD_DESCALE:
            begin
                if (sh_mode == MODE_NONE)
                begin
                    r.value = x;
                end
                else if (sh_mode == MODE_MINMAX)
                begin
                    if (cmd == CMD_SCALE)
                    begin
                        r.value = sat32(floor_mul_q(longint'(x) - stat_min[s], stat_factor[s])
                                        + sh_tmin);
                    end
                    else if (stat_factor[s] == 0)
                    begin
                        r.status = ST_ZERO;
                    end
                    else
                    begin
                        r.value = sat32((longint'(x) - sh_tmin) * 65536
                                        / longint'(stat_factor[s]) + stat_min[s]);
                    end
                end
                else
                begin
                    prod = 64'(stat_div[s])
                           * 64'((sh_mode == MODE_STDDEV) ? sh_dgain : sh_ngain);
                    d = prod >> 16;
                    if (d == 0)
                    begin
                        r.status = ST_ZERO;
                    end
                    else if (cmd == CMD_SCALE)
                    begin
                        r.value = sat32((longint'(x) - stat_mean[s]) * 65536 / d);
                    end
                    else
                    begin
                        r.value = sat32(floor_mul_q(x, d) + stat_mean[s]);
                    end
                end
            end
            default:
            begin
            end
        endcase
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("MISMATCH %s: got %h, expected %h", what, got, want);
        mismatches++;
    endtask

    always @(posedge clk)
    begin
        m_tready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge clk)
    begin
        norm_result_t exp_r;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_results.size() == 0)
            begin
                report_mismatch("unexpected result transfer", m_tdata, 32'h0);
            end
            else
            begin
                exp_r = pending_results.pop_front();
                if (m_tdata !== exp_r.value)
                begin
                    report_mismatch("result_value", m_tdata, exp_r.value);
                end
                if (m_tuser !== exp_r.status)
                begin
                    report_mismatch("status", m_tuser, exp_r.status);
                end
            end
        end
    end

    task automatic send_command(input logic [2:0] cmd, input logic sd,
                                input logic signed [31:0] x);
        while ($urandom_range(99) < idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= x;
        s_tuser <= {sd, cmd};
        do
        begin
            @(posedge clk);
        end
        while (!s_tready);
        pending_results.push_back(predict_result(cmd, sd, x));
    endtask

    task automatic drain;
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        drain();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_MODE:       sh_mode = val[1:0];
            REG_TARGET_MIN: sh_tmin = val;
            REG_TARGET_MAX: sh_tmax = val;
            REG_DEV_GAIN:   sh_dgain = val[30:0];
            REG_NORM_GAIN:  sh_ngain = val[30:0];
            default:
            begin
            end
        endcase
    endtask

    function automatic logic [31:0] random_q();
        case ($urandom_range(7))
            0: return Q_MAX;
            1: return Q_MIN;
            2: return $urandom_range(2097152) - 1048576;
            3: return $urandom_range(8) - 4;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] random_gain();
        case ($urandom_range(5))
            0: return 1;
            1: return 32'h7fff_ffff;
            2: return 32'h0001_0000;
            3: return $urandom_range(32'h0004_0000, 1);
            default: return $urandom_range(32'h7fff_ffff, 1);
        endcase
    endfunction

    task automatic randomise_config;
        write_reg(REG_MODE, $urandom_range(3));
        write_reg(REG_TARGET_MIN, ($urandom_range(1) == 0) ? random_q()
                                                           : -($urandom_range(65536 * 4)));
        write_reg(REG_TARGET_MAX, ($urandom_range(1) == 0) ? random_q()
                                                           : $urandom_range(65536 * 4));
        write_reg(REG_DEV_GAIN, random_gain());
        write_reg(REG_NORM_GAIN, random_gain());
    endtask

    task automatic test_reset_state;
        send_command(CMD_SCALE, 1'b0, Q_MAX);
        send_command(CMD_DESCALE, 1'b1, Q_MIN);
        send_command(3'd5, 1'b0, 32'h1234_5678);
        send_command(3'd6, 1'b1, 32'hffff_ffff);
        send_command(3'd7, 1'b0, 32'h0);
        send_command(CMD_FINALIZE, 1'b0, 32'h0);
        send_command(CMD_LOAD, 1'b0, Q_MAX);
        send_command(CMD_LOAD, 1'b0, Q_MIN);
        send_command(CMD_LOAD, 1'b0, 32'h0);
    endtask

    task automatic test_special_cases;
        write_reg(REG_MODE, MODE_MINMAX);
        send_command(CMD_SCALE, 1'b1, 32'h0001_0000);
        send_command(CMD_FINALIZE, 1'b1, 32'h0);
        send_command(CMD_FINALIZE, 1'b0, 32'h0);
        send_command(CMD_SCALE, 1'b0, Q_MAX);
        send_command(CMD_SCALE, 1'b0, Q_MIN);
        send_command(CMD_DESCALE, 1'b0, Q_MAX);
        send_command(CMD_LOAD, 1'b1, 32'h0003_0000);
        send_command(CMD_LOAD, 1'b1, 32'h0003_0000);
        send_command(CMD_FINALIZE, 1'b1, 32'h0);
        write_reg(REG_MODE, MODE_STDDEV);
        send_command(CMD_CLEAR, 1'b1, 32'h0);
        send_command(CMD_LOAD, 1'b1, 32'h0002_0000);
        send_command(CMD_FINALIZE, 1'b1, 32'h0);
        send_command(CMD_LOAD, 1'b1, 32'h0002_0000);
        send_command(CMD_FINALIZE, 1'b1, 32'h0);
        write_reg(REG_MODE, MODE_UNIFORM);
        send_command(CMD_FINALIZE, 1'b1, 32'h0);
        write_reg(REG_TARGET_MIN, 32'h0000_4000);
        write_reg(REG_TARGET_MAX, 32'h0000_4000);
        write_reg(REG_MODE, MODE_MINMAX);
        send_command(CMD_FINALIZE, 1'b0, 32'h0);
        send_command(CMD_DESCALE, 1'b0, 32'h0001_0000);
        write_reg(REG_DEV_GAIN, 32'h1);
        write_reg(REG_MODE, MODE_STDDEV);
        send_command(CMD_CLEAR, 1'b0, 32'h0);
        send_command(CMD_LOAD, 1'b0, 32'h0);
        send_command(CMD_LOAD, 1'b0, 32'h2);
        send_command(CMD_FINALIZE, 1'b0, 32'h0);
        send_command(CMD_SCALE, 1'b0, 32'h5);
        send_command(CMD_DESCALE, 1'b0, 32'h5);
    endtask

    task automatic test_buffer_full;
        write_reg(REG_MODE, MODE_STDDEV);
        write_reg(REG_DEV_GAIN, 32'h7fff_ffff);
        send_command(CMD_CLEAR, 1'b1, 32'h0);
        for (int i = 0; i < 258; i++)
        begin
            send_command(CMD_LOAD, 1'b1, random_q());
        end
        send_command(CMD_FINALIZE, 1'b1, 32'h0);
        send_command(CMD_SCALE, 1'b1, random_q());
        send_command(CMD_DESCALE, 1'b1, random_q());
    endtask

    task automatic test_random_traffic(input int idle, input int stall, input int items);
        int sent;
        int loads;
        logic sd;
        drain();
        idle_pct = idle;
        stall_pct = stall;
        randomise_config();
        sent = 0;
        while (sent < items)
        begin
            sd = $urandom_range(1);
            if ($urandom_range(99) < 80)
            begin
                if ($urandom_range(1) == 0)
                begin
                    send_command(CMD_CLEAR, sd, $urandom);
                    sent++;
                end
                loads = ($urandom_range(9) == 0) ? $urandom_range(40, 1) : $urandom_range(12, 1);
                for (int i = 0; i < loads; i++)
                begin
                    send_command(CMD_LOAD, sd, random_q());
                end
                send_command(CMD_FINALIZE, sd, $urandom);
                sent += loads + 1;
                for (int i = $urandom_range(4, 1); i > 0; i--)
                begin
                    send_command($urandom_range(1) ? CMD_SCALE : CMD_DESCALE, sd, random_q());
                    sent++;
                end
            end
            else
            begin
                send_command($urandom_range(7), sd, $urandom);
                sent++;
            end
            if ($urandom_range(19) == 0)
            begin
                randomise_config();
            end
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        s_tvalid <= 1'b0;
        s_tdata <= '0;
        s_tuser <= '0;
        m_tready <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data <= '0;
        mismatches = 0;
        idle_pct = 0;
        stall_pct = 0;
        sh_mode = MODE_NONE;
        sh_tmin = -32'sd65536;
        sh_tmax = 32'sd65536;
        sh_dgain = 31'd65536;
        sh_ngain = 31'd65536;
        for (int s = 0; s < 2; s++)
        begin
            buf_count[s] = 0;
            buf_sum[s] = 0;
            stat_min[s] = Q_MAX;
            stat_max[s] = Q_MIN;
            stat_mean[s] = 0;
            stat_div[s] = 32'h0001_0000;
            stat_factor[s] = 32'sh0001_0000;
        end
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_state();
        test_special_cases();
        test_buffer_full();
        test_random_traffic(0, 0, 120);
        test_random_traffic(53, 0, 120);
        test_random_traffic(0, 53, 120);
        test_random_traffic(13, 13, 120);
        test_random_traffic(0, 0, 60);
        drain();
        repeat (300) @(posedge clk);
        if (mismatches == 0 && pending_results.size() == 0)
        begin
            $display("feature_normalization_engine_top verification clean");
        end
        else
        begin
            $display("feature_normalization_engine_top verification failed");
        end
        $finish;
    end
endmodule

// File: feature_normalization_engine_top.f
+incdir+src
src/fne_pkg.sv
src/fne_ram.sv
src/feature_normalization_engine_top.sv
src/fne_checker.sv
dv/tb.sv
